FILE: rtl/bcp_pkg.sv
package bcp_pkg;

    localparam logic [2:0] REG_UPRIGHT_KP     = 3'd0;
    localparam logic [2:0] REG_UPRIGHT_KD     = 3'd1;
    localparam logic [2:0] REG_SPEED_KP       = 3'd2;
    localparam logic [2:0] REG_SPEED_KI       = 3'd3;
    localparam logic [2:0] REG_STEER_KP       = 3'd4;
    localparam logic [2:0] REG_STEER_KD       = 3'd5;
    localparam logic [2:0] REG_BALANCE_OFFSET = 3'd6;
    localparam logic [2:0] REG_MOTOR_LIMIT    = 3'd7;

    localparam logic [14:0] MOTOR_LIMIT_RESET = 15'd7000;

    localparam logic [1:0] PAIR_FILT    = 2'd0;
    localparam logic [1:0] PAIR_SPEED   = 2'd1;
    localparam logic [1:0] PAIR_UPRIGHT = 2'd2;
    localparam logic [1:0] PAIR_STEER   = 2'd3;

    localparam logic signed [16:0] FILT_NEW = 17'sd77;
    localparam logic signed [16:0] FILT_OLD = 17'sd179;
    localparam logic signed [20:0] INTEG_LIMIT = 21'sd20000;

    typedef struct packed {
        logic signed [15:0] upright_kp;
        logic signed [15:0] upright_kd;
        logic signed [15:0] speed_kp;
        logic signed [15:0] speed_ki;
        logic signed [15:0] steer_kp;
        logic signed [15:0] steer_kd;
        logic signed [15:0] balance_offset;
        logic        [14:0] motor_limit;
    } t_cfg;

    typedef struct packed {
        logic       capture;
        logic       mul;
        logic       sel_second;
        logic [1:0] pair;
        logic       acc_load;
        logic       acc_add;
        logic       latch;
        logic       mix;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/bcp_cfg.sv
module bcp_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output bcp_pkg::t_cfg      o_cfg
);

    bcp_pkg::t_cfg r_cfg;
    logic          w_wr;
    logic [2:0]    w_idx;

    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = paddr[4:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.upright_kp     <= '0;
            r_cfg.upright_kd     <= '0;
            r_cfg.speed_kp       <= '0;
            r_cfg.speed_ki       <= '0;
            r_cfg.steer_kp       <= '0;
            r_cfg.steer_kd       <= '0;
            r_cfg.balance_offset <= '0;
            r_cfg.motor_limit    <= bcp_pkg::MOTOR_LIMIT_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                bcp_pkg::REG_UPRIGHT_KP:     r_cfg.upright_kp     <= pwdata[15:0];
                bcp_pkg::REG_UPRIGHT_KD:     r_cfg.upright_kd     <= pwdata[15:0];
                bcp_pkg::REG_SPEED_KP:       r_cfg.speed_kp       <= pwdata[15:0];
                bcp_pkg::REG_SPEED_KI:       r_cfg.speed_ki       <= pwdata[15:0];
                bcp_pkg::REG_STEER_KP:       r_cfg.steer_kp       <= pwdata[15:0];
                bcp_pkg::REG_STEER_KD:       r_cfg.steer_kd       <= pwdata[15:0];
                bcp_pkg::REG_BALANCE_OFFSET: r_cfg.balance_offset <= pwdata[15:0];
                bcp_pkg::REG_MOTOR_LIMIT:    r_cfg.motor_limit    <= pwdata[14:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            bcp_pkg::REG_UPRIGHT_KP:     prdata = 32'(r_cfg.upright_kp);
            bcp_pkg::REG_UPRIGHT_KD:     prdata = 32'(r_cfg.upright_kd);
            bcp_pkg::REG_SPEED_KP:       prdata = 32'(r_cfg.speed_kp);
            bcp_pkg::REG_SPEED_KI:       prdata = 32'(r_cfg.speed_ki);
            bcp_pkg::REG_STEER_KP:       prdata = 32'(r_cfg.steer_kp);
            bcp_pkg::REG_STEER_KD:       prdata = 32'(r_cfg.steer_kd);
            bcp_pkg::REG_BALANCE_OFFSET: prdata = 32'(r_cfg.balance_offset);
            bcp_pkg::REG_MOTOR_LIMIT:    prdata = {17'd0, r_cfg.motor_limit};
            default:                     prdata = '0;
        endcase
    end

endmodule

FILE: rtl/bcp_ctrl.sv
module bcp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  bcp_pkg::t_sts i_sts,
    output bcp_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL0  = 3'd1;
    localparam logic [2:0] S_MUL1  = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_LATCH = 3'd4;
    localparam logic [2:0] S_MIX   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [1:0] r_pair;
    logic [1:0] n_pair;

    assign o_in_ready = i_rst_n && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pair  <= bcp_pkg::PAIR_FILT;
        end else begin
            r_state <= n_state;
            r_pair  <= n_pair;
        end
    end

    always_comb begin
        n_state = r_state;
        n_pair  = r_pair;
        o_cmd   = '0;
        o_cmd.pair = r_pair;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_pair  = bcp_pkg::PAIR_FILT;
                    n_state = S_MUL0;
                end
            end
            S_MUL0: begin
                o_cmd.mul = 1'b1;
                n_state   = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul        = 1'b1;
                o_cmd.sel_second = 1'b1;
                o_cmd.acc_load   = 1'b1;
                n_state          = S_ADD;
            end
            S_ADD: begin
                o_cmd.acc_add = 1'b1;
                n_state       = S_LATCH;
            end
            S_LATCH: begin
                o_cmd.latch = 1'b1;
                if (r_pair == bcp_pkg::PAIR_STEER) begin
                    n_state = S_MIX;
                end else begin
                    n_pair  = r_pair + 2'd1;
                    n_state = S_MUL0;
                end
            end
            S_MIX: begin
                if (i_sts.out_free) begin
                    o_cmd.mix = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: rtl/bcp_dp.sv
module bcp_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bcp_pkg::t_cfg       i_cfg,
    input  bcp_pkg::t_cmd       i_cmd,
    output bcp_pkg::t_sts       o_sts,
    input  logic signed [15:0]  i_encoder_left,
    input  logic signed [15:0]  i_encoder_right,
    input  logic signed [16:0]  i_speed_target,
    input  logic signed [15:0]  i_tilt_angle,
    input  logic signed [15:0]  i_pitch_rate,
    input  logic signed [15:0]  i_yaw_rate,
    input  logic signed [15:0]  i_turn_command,
    input  logic                i_stop_request,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [15:0]  o_motor_left,
    output logic signed [15:0]  o_motor_right,
    output logic signed [31:0]  o_speed_term,
    output logic signed [31:0]  o_upright_term,
    output logic signed [31:0]  o_steer_term
);

    localparam logic signed [44:0] UPR_MAX = 45'sd2147483647;
    localparam logic signed [44:0] UPR_MIN = -45'sd2147483648;

    function automatic logic signed [15:0] sat_motor(
        input logic signed [32:0] v,
        input logic        [14:0] lim
    );
        logic signed [32:0] l;
        l = 33'($signed({1'b0, lim}));
        if (v > l) begin
            sat_motor = 16'(l);
        end else if (v < -l) begin
            sat_motor = 16'(-l);
        end else begin
            sat_motor = 16'(v);
        end
    endfunction

    logic signed [15:0] r_enc_l;
    logic signed [15:0] r_enc_r;
    logic signed [16:0] r_tgt;
    logic signed [15:0] r_tilt;
    logic signed [15:0] r_pitch;
    logic signed [15:0] r_yaw;
    logic signed [15:0] r_turn;
    logic               r_stop;

    logic signed [19:0] r_filt;
    logic signed [15:0] r_integ;
    logic signed [25:0] r_spd;
    logic signed [31:0] r_upr;
    logic signed [24:0] r_str;

    logic signed [43:0] r_prod;
    logic signed [44:0] r_acc;

    logic               r_out_valid;
    logic signed [15:0] r_ml;
    logic signed [15:0] r_mr;
    logic signed [31:0] r_o_spd;
    logic signed [31:0] r_o_upr;
    logic signed [31:0] r_o_str;

    logic signed [17:0] w_err;
    logic signed [26:0] w_ae;
    logic signed [16:0] w_a;
    logic signed [26:0] w_b;
    logic signed [43:0] w_prod;
    logic signed [44:0] w_sh;
    logic signed [19:0] w_fnew;
    logic signed [20:0] w_isum;
    logic signed [32:0] w_left;
    logic signed [32:0] w_right;

    assign w_err  = 18'(r_enc_l) + 18'(r_enc_r) - 18'(r_tgt);
    assign w_ae   = 27'(r_tilt) - 27'(r_spd) - 27'(i_cfg.balance_offset);
    assign w_prod = w_a * w_b;
    assign w_sh   = r_acc >>> 8;
    assign w_fnew = w_sh[19:0];
    assign w_isum = 21'(r_integ) + 21'(w_fnew);
    assign w_left  = 33'(r_upr) - 33'(r_str);
    assign w_right = 33'(r_upr) + 33'(r_str);

    always_comb begin
        unique case (i_cmd.pair)
            bcp_pkg::PAIR_FILT: begin
                w_a = i_cmd.sel_second ? bcp_pkg::FILT_OLD : bcp_pkg::FILT_NEW;
                w_b = i_cmd.sel_second ? 27'(r_filt) : 27'(w_err);
            end
            bcp_pkg::PAIR_SPEED: begin
                w_a = 17'(i_cmd.sel_second ? i_cfg.speed_ki : i_cfg.speed_kp);
                w_b = i_cmd.sel_second ? 27'(r_integ) : 27'(r_filt);
            end
            bcp_pkg::PAIR_UPRIGHT: begin
                w_a = 17'(i_cmd.sel_second ? i_cfg.upright_kd : i_cfg.upright_kp);
                w_b = i_cmd.sel_second ? 27'(r_pitch) : w_ae;
            end
            bcp_pkg::PAIR_STEER: begin
                w_a = 17'(i_cmd.sel_second ? i_cfg.steer_kd : i_cfg.steer_kp);
                w_b = i_cmd.sel_second ? 27'(r_yaw) : 27'(r_turn);
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_enc_l <= i_encoder_left;
            r_enc_r <= i_encoder_right;
            r_tgt   <= i_speed_target;
            r_tilt  <= i_tilt_angle;
            r_pitch <= i_pitch_rate;
            r_yaw   <= i_yaw_rate;
            r_turn  <= i_turn_command;
            r_stop  <= i_stop_request;
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod;
        end
        if (i_cmd.acc_load) begin
            r_acc <= 45'(r_prod);
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + 45'(r_prod);
        end
        if (i_cmd.latch) begin
            unique case (i_cmd.pair)
                bcp_pkg::PAIR_SPEED: r_spd <= w_sh[25:0];
                bcp_pkg::PAIR_UPRIGHT: begin
                    if (w_sh > UPR_MAX) begin
                        r_upr <= 32'(UPR_MAX);
                    end else if (w_sh < UPR_MIN) begin
                        r_upr <= 32'(UPR_MIN);
                    end else begin
                        r_upr <= w_sh[31:0];
                    end
                end
                bcp_pkg::PAIR_STEER: r_str <= w_sh[24:0];
                default: begin
                end
            endcase
        end
        if (i_cmd.mix) begin
            r_ml    <= sat_motor(w_left, i_cfg.motor_limit);
            r_mr    <= sat_motor(w_right, i_cfg.motor_limit);
            r_o_spd <= 32'(r_spd);
            r_o_upr <= r_upr;
            r_o_str <= 32'(r_str);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt      <= '0;
            r_integ     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.latch && i_cmd.pair == bcp_pkg::PAIR_FILT) begin
                r_filt <= w_fnew;
                if (r_stop) begin
                    r_integ <= '0;
                end else if (w_isum > bcp_pkg::INTEG_LIMIT) begin
                    r_integ <= 16'(bcp_pkg::INTEG_LIMIT);
                end else if (w_isum < -bcp_pkg::INTEG_LIMIT) begin
                    r_integ <= 16'(-bcp_pkg::INTEG_LIMIT);
                end else begin
                    r_integ <= w_isum[15:0];
                end
            end
            if (i_cmd.mix) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_motor_left   = r_ml;
    assign o_motor_right  = r_mr;
    assign o_speed_term   = r_o_spd;
    assign o_upright_term = r_o_upr;
    assign o_steer_term   = r_o_str;

    a_integ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_integ <= 16'sd20000 && r_integ >= -16'sd20000)
        else $error("speed integral out of range");

    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.latch && i_cmd.pair == bcp_pkg::PAIR_FILT && r_stop |=> r_integ == 16'sd0)
        else $error("stop request did not clear integral");

    a_mix_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mix |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten while pending");

    a_motor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_ml <= $signed({1'b0, i_cfg.motor_limit})
                         && r_ml >= -$signed({1'b0, i_cfg.motor_limit})
                         && r_mr <= $signed({1'b0, i_cfg.motor_limit})
                         && r_mr >= -$signed({1'b0, i_cfg.motor_limit})))
        else $error("motor command exceeds limit");

endmodule

FILE: rtl/balance_cascade_pid.sv
// Cascaded speed / upright / turn controller for a two-wheel balancing body.
// Input channel (i_in_valid / o_in_ready) carries one control tick: both
// encoder counts, speed target, tilt, pitch and yaw rates, turn command and
// stop request. Output channel (o_out_valid / i_out_ready) returns both motor
// commands plus the speed, upright and turn terms of that tick.
// Gains, balance offset and motor limit are written over the APB port;
// write them only while no tick is in flight.
// One shared 17x27 multiplier works through eight products, one product pair
// at a time (two multiplies, an accumulate and a result latch), then a
// mixing step loads the output register; a new tick is taken only once the
// controller is back in idle after the mixing step.
// The output register holds a finished result while the next tick is
// computed; if the receiver stalls, the next result waits in the mixing
// step until the output register is free, and input acceptance stops.
// Reset (synchronous, active low) clears the filter and integral state,
// drops any pending result and restores register defaults (limit 7000).
module balance_cascade_pid (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic signed [15:0]  i_encoder_left,
    input  logic signed [15:0]  i_encoder_right,
    input  logic signed [16:0]  i_speed_target,
    input  logic signed [15:0]  i_tilt_angle,
    input  logic signed [15:0]  i_pitch_rate,
    input  logic signed [15:0]  i_yaw_rate,
    input  logic signed [15:0]  i_turn_command,
    input  logic                i_stop_request,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [15:0]  o_motor_left,
    output logic signed [15:0]  o_motor_right,
    output logic signed [31:0]  o_speed_term,
    output logic signed [31:0]  o_upright_term,
    output logic signed [31:0]  o_steer_term
);

    bcp_pkg::t_cfg w_cfg;
    bcp_pkg::t_cmd w_cmd;
    bcp_pkg::t_sts w_sts;

    bcp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    bcp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    bcp_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_encoder_left  (i_encoder_left),
        .i_encoder_right (i_encoder_right),
        .i_speed_target  (i_speed_target),
        .i_tilt_angle    (i_tilt_angle),
        .i_pitch_rate    (i_pitch_rate),
        .i_yaw_rate      (i_yaw_rate),
        .i_turn_command  (i_turn_command),
        .i_stop_request  (i_stop_request),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_motor_left    (o_motor_left),
        .o_motor_right   (o_motor_right),
        .o_speed_term    (o_speed_term),
        .o_upright_term  (o_upright_term),
        .o_steer_term    (o_steer_term)
    );

endmodule
